[design/ecl_pkg.sv]
// package for the expression character lexer: token kinds, error codes,
// lexer modes, result records and the character classification functions
// no dependencies
package ecl_pkg;

  // queue between the classifier and the result sequencer
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned MaxRes = 3;

  typedef logic [4:0] kind_t;
  typedef logic [2:0] err_t;
  typedef logic [1:0] rcnt_t;

  // token kinds
  localparam kind_t K_INT   = 5'd0;
  localparam kind_t K_IDENT = 5'd1;
  localparam kind_t K_ADD   = 5'd2;
  localparam kind_t K_SUB   = 5'd3;
  localparam kind_t K_MUL   = 5'd4;
  localparam kind_t K_DIV   = 5'd5;
  localparam kind_t K_MOD   = 5'd6;
  localparam kind_t K_XOR   = 5'd7;
  localparam kind_t K_INV   = 5'd8;
  localparam kind_t K_QUES  = 5'd9;
  localparam kind_t K_COLON = 5'd10;
  localparam kind_t K_LT    = 5'd11;
  localparam kind_t K_LE    = 5'd12;
  localparam kind_t K_SHL   = 5'd13;
  localparam kind_t K_GT    = 5'd14;
  localparam kind_t K_GE    = 5'd15;
  localparam kind_t K_SHR   = 5'd16;
  localparam kind_t K_NOT   = 5'd17;
  localparam kind_t K_NE    = 5'd18;
  localparam kind_t K_EQ    = 5'd19;
  localparam kind_t K_BAND  = 5'd20;
  localparam kind_t K_LAND  = 5'd21;
  localparam kind_t K_BOR   = 5'd22;
  localparam kind_t K_LOR   = 5'd23;
  localparam kind_t K_LPAR  = 5'd24;
  localparam kind_t K_RPAR  = 5'd25;
  localparam kind_t K_LBRK  = 5'd26;
  localparam kind_t K_RBRK  = 5'd27;
  localparam kind_t K_STR   = 5'd28;
  localparam kind_t K_NONE  = 5'd31;

  // error codes
  localparam err_t E_OK         = 3'd0;
  localparam err_t E_EMPTY_HEX  = 3'd1;
  localparam err_t E_BAD_EQUAL  = 3'd2;
  localparam err_t E_OPEN_STR   = 3'd3;
  localparam err_t E_BAD_CHAR   = 3'd4;

  // characters
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CASE_BIT = 8'h20;

  typedef enum logic [2:0] {
    M_IDLE,
    M_DEC,
    M_HEX0,
    M_HEX,
    M_OP,
    M_QOPEN,
    M_QIN
  } mode_e;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
    logic       has;
    logic       st;
    logic       en;
    err_t       err;
    logic       done;
    logic       last;
  } res_t;

  // all results caused by one accepted byte
  typedef struct packed {
    rcnt_t                  cnt;
    res_t [MaxRes-1:0]      rec;
  } bundle_t;

  function automatic res_t mk_res(kind_t kind, logic [7:0] ch, logic has, logic st,
                                  logic en, err_t err);
    res_t r;
    r.kind = kind;
    r.ch   = ch;
    r.has  = has;
    r.st   = st;
    r.en   = en;
    r.err  = err;
    r.done = 1'b0;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic logic is_dec(logic [7:0] c);
    return c inside {[CH_0:CH_9]};
  endfunction

  function automatic logic is_hexd(logic [7:0] c);
    return c inside {[CH_0:CH_9], [CH_LA:CH_LF], [CH_UA:CH_UF]};
  endfunction

  function automatic kind_t single_kind(logic [7:0] c);
    kind_t k;
    case (c)
      CH_T:     k = K_IDENT;
      CH_PLUS:  k = K_ADD;
      CH_MINUS: k = K_SUB;
      CH_STAR:  k = K_MUL;
      CH_SLASH: k = K_DIV;
      CH_PCT:   k = K_MOD;
      CH_CARET: k = K_XOR;
      CH_TILDE: k = K_INV;
      CH_QMARK: k = K_QUES;
      CH_COLON: k = K_COLON;
      CH_LPAR:  k = K_LPAR;
      CH_RPAR:  k = K_RPAR;
      CH_LBRK:  k = K_LBRK;
      CH_RBRK:  k = K_RBRK;
      default:  k = K_NONE;
    endcase
    return k;
  endfunction

  function automatic kind_t pending_kind(logic [7:0] c);
    kind_t k;
    case (c)
      CH_LT:   k = K_LT;
      CH_GT:   k = K_GT;
      CH_BANG: k = K_NOT;
      CH_EQ:   k = K_EQ;
      CH_AMP:  k = K_BAND;
      CH_BAR:  k = K_BOR;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

  function automatic kind_t pair_kind(logic [7:0] a, logic [7:0] b);
    kind_t k;
    case ({a, b})
      {CH_LT, CH_LT}:     k = K_SHL;
      {CH_LT, CH_EQ}:     k = K_LE;
      {CH_GT, CH_GT}:     k = K_SHR;
      {CH_GT, CH_EQ}:     k = K_GE;
      {CH_BANG, CH_EQ}:   k = K_NE;
      {CH_EQ, CH_EQ}:     k = K_EQ;
      {CH_AMP, CH_AMP}:   k = K_LAND;
      {CH_BAR, CH_BAR}:   k = K_LOR;
      default:            k = K_NONE;
    endcase
    return k;
  endfunction

endpackage

[design/expression_char_lexer_unit.sv]
// top level of the expression character lexer
// uses ecl_pkg, ecl_front, ecl_queue, ecl_back
//
// usage
//   input channel: one text byte per item (in_char_i) with end_of_input_i on
//   the final byte of an expression; in_valid_i / in_ready_o handshake
//   output channel: one lexeme character per item with kind, start and end
//   marks, error code, stream_done and last; out_valid_o / out_ready_i
//   an accepted byte causes zero to three output items; bytes causing none
//   (spaces, the first character of a held token, bytes after an error)
//   produce nothing on the output
//   path: with queue and output register empty, an accepted byte's results
//   are written into the queue as one bundle and then loaded into the output register
//   throughput: one byte per cycle while each byte causes at most one
//   result and the receiver is ready; the results of one byte pass the output
//   register in turn, and the four-entry bundle queue absorbs short bursts
//   when the receiver stalls, results wait in the output register and the
//   queue; in_ready_o falls only once the queue is full
//   reset: lexer returns to idle between tokens, queue and output empty;
//   end of input also returns the lexer to that state
module expression_char_lexer_unit
  import ecl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_char_i,
  input  logic       end_of_input_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [4:0] token_kind_o,
  output logic [7:0] lexeme_char_o,
  output logic       has_char_o,
  output logic       token_start_o,
  output logic       token_end_o,
  output logic [2:0] error_code_o,
  output logic       stream_done_o,
  output logic       last_o
);

  logic    q_full, q_empty;
  logic    push, pop;
  logic    in_acc;
  bundle_t front_bundle, head_bundle;
  res_t    out_rec;

  // front stalls only when the bundle queue has no room
  assign in_ready_o = !q_full;
  assign in_acc     = in_valid_i && in_ready_o;

  // classifier: lexer state advances on every accepted byte
  ecl_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_acc),
    .char_i   (in_char_i),
    .eoi_i    (end_of_input_i),
    .push_o   (push),
    .bundle_o (front_bundle)
  );

  // decouples byte intake from result delivery
  ecl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .din_i   (front_bundle),
    .full_o  (q_full),
    .pop_i   (pop),
    .dout_o  (head_bundle),
    .empty_o (q_empty)
  );

  // serializes each bundle into single output items
  ecl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_bundle),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_rec)
  );

  assign token_kind_o  = out_rec.kind;
  assign lexeme_char_o = out_rec.ch;
  assign has_char_o    = out_rec.has;
  assign token_start_o = out_rec.st;
  assign token_end_o   = out_rec.en;
  assign error_code_o  = out_rec.err;
  assign stream_done_o = out_rec.done;
  assign last_o        = out_rec.last;

endmodule

[design/ecl_front.sv]
// classifier of the expression character lexer: lexer state and the
// bundle of results for each accepted byte; uses ecl_pkg
module ecl_front
  import ecl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] char_i,
  input  logic       eoi_i,
  output logic       push_o,
  output bundle_t    bundle_o
);

  mode_e      mode_q, mode_d;
  logic [7:0] hc_q, hc_d;
  kind_t      hk_q, hk_d;
  logic       hs_q, hs_d;
  logic       lz_q, lz_d;
  logic       el_q, el_d;

  always_comb begin
    mode_e             mode;
    logic [7:0]        hc;
    kind_t             hk;
    logic              hs;
    logic              lz;
    logic              el;
    logic              do_begin;
    kind_t             k;
    rcnt_t             n;
    res_t [MaxRes-1:0] rec;

    mode     = mode_q;
    hc       = hc_q;
    hk       = hk_q;
    hs       = hs_q;
    lz       = lz_q;
    el       = el_q;
    do_begin = 1'b0;
    k        = K_NONE;
    n        = '0;
    rec      = '0;

    if (!el_q) begin
      case (mode_q)
        M_DEC: begin
          if (is_dec(char_i)) begin
            rec[n] = mk_res(hk, hc, 1'b1, hs, 1'b0, E_OK);
            n = n + 2'd1;
            hc = char_i; hk = K_INT; hs = 1'b0; lz = 1'b0;
          end else if (((char_i | CASE_BIT) == CH_X) && lz_q) begin
            rec[n] = mk_res(hk, hc, 1'b1, hs, 1'b0, E_OK);
            n = n + 2'd1;
            hc = char_i; hk = K_INT; hs = 1'b0; lz = 1'b0;
            mode = M_HEX0;
          end else begin
            rec[n] = mk_res(hk, hc, 1'b1, hs, 1'b1, E_OK);
            n = n + 2'd1;
            do_begin = 1'b1;
          end
        end
        M_HEX0: begin
          if (is_hexd(char_i)) begin
            rec[n] = mk_res(hk, hc, 1'b1, hs, 1'b0, E_OK);
            n = n + 2'd1;
            hc = char_i; hk = K_INT; hs = 1'b0;
            mode = M_HEX;
          end else begin
            rec[n] = mk_res(K_INT, 8'h00, 1'b0, 1'b0, 1'b0, E_EMPTY_HEX);
            n = n + 2'd1;
            el = 1'b1;
            mode = M_IDLE;
          end
        end
        M_HEX: begin
          if (is_hexd(char_i)) begin
            rec[n] = mk_res(hk, hc, 1'b1, hs, 1'b0, E_OK);
            n = n + 2'd1;
            hc = char_i; hk = K_INT; hs = 1'b0;
          end else begin
            rec[n] = mk_res(hk, hc, 1'b1, hs, 1'b1, E_OK);
            n = n + 2'd1;
            do_begin = 1'b1;
          end
        end
        M_OP: begin
          k = pair_kind(hc_q, char_i);
          if (k != K_NONE) begin
            rec[n] = mk_res(k, hc_q, 1'b1, 1'b1, 1'b0, E_OK);
            n = n + 2'd1;
            rec[n] = mk_res(k, char_i, 1'b1, 1'b0, 1'b1, E_OK);
            n = n + 2'd1;
            mode = M_IDLE;
          end else if (hc_q == CH_EQ) begin
            rec[n] = mk_res(K_INT, 8'h00, 1'b0, 1'b0, 1'b0, E_BAD_EQUAL);
            n = n + 2'd1;
            el = 1'b1;
            mode = M_IDLE;
          end else begin
            rec[n] = mk_res(hk, hc, 1'b1, hs, 1'b1, E_OK);
            n = n + 2'd1;
            do_begin = 1'b1;
          end
        end
        M_QOPEN: begin
          if (char_i == CH_QUOTE) begin
            rec[n] = mk_res(K_STR, 8'h00, 1'b0, 1'b1, 1'b1, E_OK);
            n = n + 2'd1;
            mode = M_IDLE;
          end else begin
            hc = char_i; hk = K_STR; hs = 1'b1;
            mode = M_QIN;
          end
        end
        M_QIN: begin
          if (char_i == CH_QUOTE) begin
            rec[n] = mk_res(hk, hc, 1'b1, hs, 1'b1, E_OK);
            n = n + 2'd1;
            mode = M_IDLE;
          end else begin
            rec[n] = mk_res(hk, hc, 1'b1, hs, 1'b0, E_OK);
            n = n + 2'd1;
            hc = char_i; hk = K_STR; hs = 1'b0;
          end
        end
        default: begin
          do_begin = 1'b1;
        end
      endcase

      // byte starts a fresh token
      if (do_begin) begin
        mode = M_IDLE;
        if (char_i == CH_SPACE) begin
          mode = M_IDLE;
        end else if (is_dec(char_i)) begin
          hc = char_i; hk = K_INT; hs = 1'b1;
          lz = (char_i == CH_0);
          mode = M_DEC;
        end else if (single_kind(char_i) != K_NONE) begin
          rec[n] = mk_res(single_kind(char_i), char_i, 1'b1, 1'b1, 1'b1, E_OK);
          n = n + 2'd1;
        end else if (pending_kind(char_i) != K_NONE) begin
          hc = char_i; hk = pending_kind(char_i); hs = 1'b1;
          mode = M_OP;
        end else if (char_i == CH_QUOTE) begin
          mode = M_QOPEN;
        end else begin
          rec[n] = mk_res(K_INT, 8'h00, 1'b0, 1'b0, 1'b0, E_BAD_CHAR);
          n = n + 2'd1;
          el = 1'b1;
          mode = M_IDLE;
        end
      end
    end

    if (eoi_i) begin
      // flush whatever is pending
      if (!el) begin
        case (mode)
          M_DEC, M_HEX: begin
            rec[n] = mk_res(hk, hc, 1'b1, hs, 1'b1, E_OK);
            n = n + 2'd1;
          end
          M_HEX0: begin
            rec[n] = mk_res(K_INT, 8'h00, 1'b0, 1'b0, 1'b0, E_EMPTY_HEX);
            n = n + 2'd1;
          end
          M_OP: begin
            if (hc == CH_EQ) begin
              rec[n] = mk_res(K_INT, 8'h00, 1'b0, 1'b0, 1'b0, E_BAD_EQUAL);
            end else begin
              rec[n] = mk_res(hk, hc, 1'b1, hs, 1'b1, E_OK);
            end
            n = n + 2'd1;
          end
          M_QOPEN, M_QIN: begin
            rec[n] = mk_res(K_INT, 8'h00, 1'b0, 1'b0, 1'b0, E_OPEN_STR);
            n = n + 2'd1;
          end
          default: begin
          end
        endcase
      end
      if (n == '0) begin
        rec[n] = mk_res(K_INT, 8'h00, 1'b0, 1'b0, 1'b0, E_OK);
        n = n + 2'd1;
      end
      rec[n - 2'd1].done = 1'b1;
      mode = M_IDLE;
      hc   = '0;
      hk   = K_INT;
      hs   = 1'b0;
      lz   = 1'b0;
      el   = 1'b0;
    end

    if (n != '0) begin
      rec[n - 2'd1].last = 1'b1;
    end

    mode_d       = mode;
    hc_d         = hc;
    hk_d         = hk;
    hs_d         = hs;
    lz_d         = lz;
    el_d         = el;
    bundle_o.cnt = n;
    bundle_o.rec = rec;
    push_o       = accept_i && (n != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      hc_q   <= '0;
      hk_q   <= K_INT;
      hs_q   <= 1'b0;
      lz_q   <= 1'b0;
      el_q   <= 1'b0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      hc_q   <= hc_d;
      hk_q   <= hk_d;
      hs_q   <= hs_d;
      lz_q   <= lz_d;
      el_q   <= el_d;
    end
  end

endmodule

[design/ecl_queue.sv]
// small queue of result bundles between classifier and sequencer
// uses ecl_pkg
module ecl_queue
  import ecl_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bundle_t din_i,
  output logic    full_o,
  input  logic    pop_i,
  output bundle_t dout_o,
  output logic    empty_o
);

  localparam int unsigned CntW = $clog2(QDepth + 1);

  bundle_t           mem_q [QDepth];
  logic [QPtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign dout_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= din_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[design/ecl_back.sv]
// result sequencer: walks the records of the head bundle into the output
// register, one per cycle unless the receiver holds the output; uses ecl_pkg
module ecl_back
  import ecl_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  bundle_t head_i,
  input  logic    empty_i,
  output logic    pop_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output res_t    out_o
);

  logic  ov_q;
  res_t  out_q;
  rcnt_t idx_q;
  logic  load;
  logic  final_rec;

  assign load        = !empty_i && (!ov_q || out_ready_i);
  assign final_rec   = (idx_q == (head_i.cnt - 2'd1));
  assign pop_o       = load && final_rec;
  assign out_valid_o = ov_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= head_i.rec[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q  <= 1'b0;
      idx_q <= '0;
    end else begin
      ov_q <= load || (ov_q && !out_ready_i);
      if (load) begin
        idx_q <= final_rec ? '0 : idx_q + 2'd1;
      end
    end
  end

endmodule

[tb/ecl_lexeme_checker.sv]
// result checker for the expression character lexer: mirrors the lexer state,
// predicts the lexeme results of every accepted byte and compares them in order
// depends on ecl_pkg for kinds, error codes, modes and the result record
module ecl_lexeme_checker
  import ecl_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [7:0]        in_char_i,
  input  logic              end_of_input_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [4:0]        token_kind_i,
  input  logic [7:0]        lexeme_char_i,
  input  logic              has_char_i,
  input  logic              token_start_i,
  input  logic              token_end_i,
  input  logic [2:0]        error_code_i,
  input  logic              stream_done_i,
  input  logic              last_i,
  output int unsigned       fail_count_o,
  output int unsigned       outstanding_o,
  output int unsigned       checked_o
);

  // lexer state as predicted
  mode_e      lx_mode;
  logic [7:0] hold_ch;
  kind_t      hold_kind;
  logic       hold_first;
  logic       lone_zero;
  logic       err_seen;

  // results of the byte being lexed, then the expected lexeme results in order
  res_t        step_res [MaxRes];
  int unsigned step_n;
  res_t        lexeme_q [$];

  int unsigned fails;
  int unsigned checked;

  function automatic logic digit_char(logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic hex_char(logic [7:0] c);
    return digit_char(c) || ((c >= CH_LA) && (c <= CH_LF)) || ((c >= CH_UA) && (c <= CH_UF));
  endfunction

  // operators complete in one byte, and t
  function automatic kind_t solo_kind(logic [7:0] c);
    case (c)
      CH_T:     return K_IDENT;
      CH_PLUS:  return K_ADD;
      CH_MINUS: return K_SUB;
      CH_STAR:  return K_MUL;
      CH_SLASH: return K_DIV;
      CH_PCT:   return K_MOD;
      CH_CARET: return K_XOR;
      CH_TILDE: return K_INV;
      CH_QMARK: return K_QUES;
      CH_COLON: return K_COLON;
      CH_LPAR:  return K_LPAR;
      CH_RPAR:  return K_RPAR;
      CH_LBRK:  return K_LBRK;
      CH_RBRK:  return K_RBRK;
      default:  return K_NONE;
    endcase
  endfunction

  // operators that may take a second byte
  function automatic kind_t lead_kind(logic [7:0] c);
    case (c)
      CH_LT:   return K_LT;
      CH_GT:   return K_GT;
      CH_BANG: return K_NOT;
      CH_EQ:   return K_EQ;
      CH_AMP:  return K_BAND;
      CH_BAR:  return K_BOR;
      default: return K_NONE;
    endcase
  endfunction

  function automatic kind_t joined_kind(logic [7:0] a, logic [7:0] b);
    if (b == CH_EQ) begin
      case (a)
        CH_LT:   return K_LE;
        CH_GT:   return K_GE;
        CH_BANG: return K_NE;
        CH_EQ:   return K_EQ;
        default: return K_NONE;
      endcase
    end
    if (a == b) begin
      case (a)
        CH_LT:   return K_SHL;
        CH_GT:   return K_SHR;
        CH_AMP:  return K_LAND;
        CH_BAR:  return K_LOR;
        default: return K_NONE;
      endcase
    end
    return K_NONE;
  endfunction

  function automatic void add_res(kind_t k, logic [7:0] c, logic h, logic s, logic e, err_t er);
    res_t r;
    r      = '0;
    r.kind = k;
    r.ch   = c;
    r.has  = h;
    r.st   = s;
    r.en   = e;
    r.err  = er;
    if (step_n < MaxRes) begin
      step_res[step_n] = r;
      step_n++;
    end
  endfunction

  function automatic void hold_byte(logic [7:0] c, kind_t k, logic first);
    hold_ch    = c;
    hold_kind  = k;
    hold_first = first;
  endfunction

  function automatic void release_held(logic en);
    add_res(hold_kind, hold_ch, 1'b1, hold_first, en, E_OK);
  endfunction

  function automatic void lex_error(err_t code);
    add_res(K_INT, 8'h00, 1'b0, 1'b0, 1'b0, code);
    err_seen = 1'b1;
    lx_mode  = M_IDLE;
  endfunction

  function automatic void clear_lexer();
    lx_mode    = M_IDLE;
    hold_ch    = '0;
    hold_kind  = K_INT;
    hold_first = 1'b0;
    lone_zero  = 1'b0;
    err_seen   = 1'b0;
  endfunction

  function automatic void start_token(logic [7:0] c);
    kind_t solo;
    kind_t lead;
    solo    = solo_kind(c);
    lead    = lead_kind(c);
    lx_mode = M_IDLE;
    if (digit_char(c)) begin
      hold_byte(c, K_INT, 1'b1);
      lone_zero = (c == CH_0);
      lx_mode   = M_DEC;
    end else if (solo != K_NONE) begin
      add_res(solo, c, 1'b1, 1'b1, 1'b1, E_OK);
    end else if (lead != K_NONE) begin
      hold_byte(c, lead, 1'b1);
      lx_mode = M_OP;
    end else if (c == CH_QUOTE) begin
      lx_mode = M_QOPEN;
    end else if (c != CH_SPACE) begin
      lex_error(E_BAD_CHAR);
    end
  endfunction

  function automatic void feed_byte(logic [7:0] c);
    kind_t pk;
    pk = joined_kind(hold_ch, c);
    case (lx_mode)
      M_DEC: begin
        if (digit_char(c)) begin
          release_held(1'b0);
          hold_byte(c, K_INT, 1'b0);
          lone_zero = 1'b0;
        end else if (((c | CASE_BIT) == CH_X) && lone_zero) begin
          release_held(1'b0);
          hold_byte(c, K_INT, 1'b0);
          lone_zero = 1'b0;
          lx_mode   = M_HEX0;
        end else begin
          release_held(1'b1);
          start_token(c);
        end
      end
      M_HEX0: begin
        if (hex_char(c)) begin
          release_held(1'b0);
          hold_byte(c, K_INT, 1'b0);
          lx_mode = M_HEX;
        end else begin
          lex_error(E_EMPTY_HEX);
        end
      end
      M_HEX: begin
        if (hex_char(c)) begin
          release_held(1'b0);
          hold_byte(c, K_INT, 1'b0);
        end else begin
          release_held(1'b1);
          start_token(c);
        end
      end
      M_OP: begin
        if (pk != K_NONE) begin
          add_res(pk, hold_ch, 1'b1, 1'b1, 1'b0, E_OK);
          add_res(pk, c, 1'b1, 1'b0, 1'b1, E_OK);
          lx_mode = M_IDLE;
        end else if (hold_ch == CH_EQ) begin
          lex_error(E_BAD_EQUAL);
        end else begin
          release_held(1'b1);
          start_token(c);
        end
      end
      M_QOPEN: begin
        if (c == CH_QUOTE) begin
          add_res(K_STR, 8'h00, 1'b0, 1'b1, 1'b1, E_OK);
          lx_mode = M_IDLE;
        end else begin
          hold_byte(c, K_STR, 1'b1);
          lx_mode = M_QIN;
        end
      end
      M_QIN: begin
        if (c == CH_QUOTE) begin
          release_held(1'b1);
          lx_mode = M_IDLE;
        end else begin
          release_held(1'b0);
          hold_byte(c, K_STR, 1'b0);
        end
      end
      default: start_token(c);
    endcase
  endfunction

  // tokens still open at end of input
  function automatic void flush_token();
    case (lx_mode)
      M_DEC, M_HEX: release_held(1'b1);
      M_HEX0:       lex_error(E_EMPTY_HEX);
      M_OP: begin
        if (hold_ch == CH_EQ) lex_error(E_BAD_EQUAL);
        else release_held(1'b1);
      end
      M_QOPEN, M_QIN: lex_error(E_OPEN_STR);
      default: ;
    endcase
  endfunction

  function automatic void lex_byte(logic [7:0] c, logic eoi);
    logic was_latched;
    was_latched = err_seen;
    step_n      = 0;
    if (!was_latched) feed_byte(c);
    if (eoi) begin
      if (!err_seen) flush_token();
      if (step_n == 0) add_res(K_INT, 8'h00, 1'b0, 1'b0, 1'b0, E_OK);
      step_res[step_n-1].done = 1'b1;
      clear_lexer();
    end
    if (step_n > 0) step_res[step_n-1].last = 1'b1;
    for (int i = 0; i < step_n; i++) lexeme_q.insert(lexeme_q.size(), step_res[i]);
  endfunction

  function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      fails++;
    end
  endfunction

  function automatic void check_result();
    res_t want;
    if (lexeme_q.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual kind %0d char %0h err %0d",
               $time, token_kind_i, lexeme_char_i, error_code_i);
      fails++;
    end else begin
      want = lexeme_q.pop_front();
      checked++;
      compare_field("token_kind", 8'(want.kind), 8'(token_kind_i));
      compare_field("lexeme_char", want.ch, lexeme_char_i);
      compare_field("has_char", 8'(want.has), 8'(has_char_i));
      compare_field("token_start", 8'(want.st), 8'(token_start_i));
      compare_field("token_end", 8'(want.en), 8'(token_end_i));
      compare_field("error_code", 8'(want.err), 8'(error_code_i));
      compare_field("stream_done", 8'(want.done), 8'(stream_done_i));
      compare_field("last", 8'(want.last), 8'(last_i));
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_lexer();
      lexeme_q.delete();
      fails         = 0;
      checked       = 0;
      fail_count_o  <= 0;
      outstanding_o <= 0;
      checked_o     <= 0;
    end else begin
      if (out_valid_i && out_ready_i) check_result();
      if (in_valid_i && in_ready_i) lex_byte(in_char_i, end_of_input_i);
      fail_count_o  <= fails;
      outstanding_o <= lexeme_q.size();
      checked_o     <= checked;
    end
  end

endmodule

[tb/tb_top.sv]
// top of the expression character lexer testbench: clock, reset, byte stimulus,
// output back-pressure and the verdict
// depends on ecl_pkg, expression_char_lexer_unit and ecl_lexeme_checker
module tb_top
  import ecl_pkg::*;
();

  localparam int unsigned RandomBytes = 250;
  localparam int unsigned LongStall   = 64;

  // pieces an expression is built from; the last four break it
  typedef enum int unsigned {
    PC_DEC, PC_HEX, PC_VAR, PC_SOLO, PC_PAIR, PC_LEAD, PC_STR, PC_ZERO,
    PC_NOISE, PC_LONE_EQ, PC_BARE_HEX, PC_OPEN_STR
  } piece_e;

  // receiver back-pressure styles
  typedef enum int unsigned {RX_OPEN, RX_COIN, RX_SPARSE, RX_RHYTHM} rx_style_e;

  localparam logic [12:0][7:0] SoloOps = {
    CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT, CH_CARET, CH_TILDE,
    CH_QMARK, CH_COLON, CH_LPAR, CH_RPAR, CH_LBRK, CH_RBRK
  };
  localparam logic [7:0][15:0] PairOps = {
    {CH_LT, CH_LT}, {CH_LT, CH_EQ}, {CH_GT, CH_GT}, {CH_GT, CH_EQ},
    {CH_BANG, CH_EQ}, {CH_EQ, CH_EQ}, {CH_AMP, CH_AMP}, {CH_BAR, CH_BAR}
  };
  // lead characters that stand alone legally (a lone = is an error)
  localparam logic [4:0][7:0] LeadOps = {CH_LT, CH_GT, CH_BANG, CH_AMP, CH_BAR};

  logic       clk;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic [7:0] in_char   = 8'h00;
  logic       in_eoi    = 1'b0;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [4:0] token_kind;
  logic [7:0] lexeme_char;
  logic       has_char;
  logic       token_start;
  logic       token_end;
  logic [2:0] error_code;
  logic       stream_done;
  logic       last;

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned checked;

  // stimulus bookkeeping
  logic [7:0]  text_q [$];
  int unsigned burst_left     = 0;
  int unsigned sent           = 0;
  int unsigned exprs          = 0;
  logic        long_stall_req = 1'b0;

  expression_char_lexer_unit DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .in_char_i      (in_char),
    .end_of_input_i (in_eoi),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .token_kind_o   (token_kind),
    .lexeme_char_o  (lexeme_char),
    .has_char_o     (has_char),
    .token_start_o  (token_start),
    .token_end_o    (token_end),
    .error_code_o   (error_code),
    .stream_done_o  (stream_done),
    .last_o         (last)
  );

  ecl_lexeme_checker checker_i (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .in_char_i      (in_char),
    .end_of_input_i (in_eoi),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .token_kind_i   (token_kind),
    .lexeme_char_i  (lexeme_char),
    .has_char_i     (has_char),
    .token_start_i  (token_start),
    .token_end_i    (token_end),
    .error_code_i   (error_code),
    .stream_done_i  (stream_done),
    .last_i         (last),
    .fail_count_o   (fail_count),
    .outstanding_o  (outstanding),
    .checked_o      (checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // offer one byte and hold it until accepted; bursts of random length are
  // separated by random gaps, and a burst may start with no gap at all
  task automatic send_byte(input logic [7:0] c, input logic eoi);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_char  <= c;
    in_eoi   <= eoi;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // the whole expression in text_q, end of input on its final byte
  task automatic send_expression();
    for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
    exprs++;
  endtask

  // one more byte at the end of the expression text
  function automatic void append_byte(logic [7:0] c);
    text_q.insert(text_q.size(), c);
  endfunction

  function automatic void load_text(string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) append_byte(s[i]);
  endfunction

  // stop offering and let every predicted result come out
  task automatic wait_for_results();
    in_valid   <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic logic [7:0] rand_hex_digit();
    int unsigned r;
    r = $urandom_range(0, 21);
    if (r < 10) return 8'(CH_0 + r);
    if (r < 16) return 8'(CH_LA + (r - 10));
    return 8'(CH_UA + (r - 16));
  endfunction

  // mostly well-formed token sequences with random content; about one in
  // seven carries a fault somewhere, after which the rest is ignored noise
  task automatic compose_expression();
    int unsigned n_tok;
    int unsigned fault_at;
    int unsigned len;
    logic        broken;
    logic [7:0]  c;
    logic [15:0] pair;
    piece_e      pick;
    text_q.delete();
    n_tok    = $urandom_range(1, 8);
    broken   = ($urandom_range(0, 6) == 0);
    fault_at = $urandom_range(0, n_tok - 1);
    for (int i = 0; i < n_tok; i++) begin
      if ($urandom_range(0, 1)) append_byte(CH_SPACE);
      if (broken && i == fault_at) pick = piece_e'($urandom_range(PC_NOISE, PC_OPEN_STR));
      else pick = piece_e'($urandom_range(PC_DEC, PC_ZERO));
      case (pick)
        PC_DEC: begin
          // now and then a long lexeme, since lexemes are streamed
          len = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 4);
          repeat (len) append_byte(8'(CH_0 + $urandom_range(0, 9)));
        end
        PC_HEX: begin
          append_byte(CH_0);
          // upper or lower case x
          append_byte($urandom_range(0, 1) ? CH_X : (CH_X ^ CASE_BIT));
          len = $urandom_range(1, 5);
          repeat (len) append_byte(rand_hex_digit());
        end
        PC_VAR:  append_byte(CH_T);
        PC_SOLO: append_byte(SoloOps[4'($urandom_range(0, 12))]);
        PC_PAIR: begin
          pair = PairOps[3'($urandom_range(0, 7))];
          append_byte(pair[15:8]);
          append_byte(pair[7:0]);
        end
        PC_LEAD: append_byte(LeadOps[3'($urandom_range(0, 4))]);
        PC_STR: begin
          append_byte(CH_QUOTE);
          len = $urandom_range(0, 5);
          repeat (len) begin
            c = 8'($urandom_range(0, 255));
            append_byte((c == CH_QUOTE) ? CH_SPACE : c);
          end
          append_byte(CH_QUOTE);
        end
        PC_ZERO:    append_byte(CH_0);
        PC_NOISE:   append_byte(8'($urandom_range(0, 255)));
        PC_LONE_EQ: append_byte(CH_EQ);
        PC_BARE_HEX: begin
          append_byte(CH_0);
          append_byte(CH_X);
          append_byte($urandom_range(0, 1) ? CH_T : CH_SPACE);
        end
        default: begin
          // string left open up to end of input
          append_byte(CH_QUOTE);
          len = $urandom_range(0, 3);
          repeat (len) append_byte(8'(CH_LA + $urandom_range(0, 5)));
          break;
        end
      endcase
    end
    if ($urandom_range(0, 3) == 0) append_byte(CH_SPACE);
  endtask

  initial begin : stimulus
    int unsigned round;
    int unsigned target;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // hex integer, two-character comparison, variable
    load_text("0x1F<=t");
    send_expression();
    // empty string
    load_text("\"\"");
    send_expression();
    // bare 0X at end of input, then 0x followed by a non-hex byte
    load_text("0X");
    send_expression();
    load_text("0xt");
    send_expression();
    // lone equal at end of input
    load_text("=");
    send_expression();
    // string still open at end of input
    load_text("\"ab");
    send_expression();
    // byte 0xff is a bad character, the digit after it is ignored
    text_q = '{8'hFF, CH_0 + 8'd5};
    send_expression();
    // NUL as the only byte: bad character together with end of input
    text_q = '{8'h00};
    send_expression();
    // only a space: status-only result
    load_text(" ");
    send_expression();
    // lone ampersand flushed at end of input
    load_text("&");
    send_expression();
    wait_for_results();

    round  = 0;
    target = sent + RandomBytes;
    while (sent < target) begin
      // long output hold-off while bytes keep coming without gaps, so that
      // the queue fills and the input stalls
      if (round == 2) begin
        long_stall_req = 1'b1;
        burst_left     = 60;
      end
      compose_expression();
      send_expression();
      if (round == 4 || $urandom_range(0, 9) == 0) wait_for_results();
      round++;
    end

    wait_for_results();
    repeat (20) @(posedge clk);
    $display("covered %0d text bytes in %0d expressions, %0d lexeme results checked,",
             sent, exprs, checked);
    $display("with random gaps, output back-pressure and a %0d-cycle output hold-off",
             LongStall);
    if (fail_count == 0 && outstanding == 0) begin
      $display("expression_char_lexer_unit regression: pass");
    end else begin
      $display("expression_char_lexer_unit regression: fail");
    end
    $finish;
  end

  // output back-pressure: styles change after spans of random length, and the long
  // hold-off is counted here once the stimulus asks for it
  initial begin : receiver
    rx_style_e   style;
    int unsigned span;
    style = RX_OPEN;
    span  = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (long_stall_req) begin
        out_ready <= 1'b0;
        repeat (LongStall) @(posedge clk);
        long_stall_req = 1'b0;
      end else begin
        if (span == 0) begin
          style = rx_style_e'($urandom_range(RX_OPEN, RX_RHYTHM));
          span  = $urandom_range(20, 120);
        end
        span--;
        case (style)
          RX_OPEN:   out_ready <= 1'b1;
          RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
          default:   out_ready <= ((span % 3) != 0);
        endcase
      end
    end
  end

  // run limit, far beyond the slowest correct run
  initial begin : watchdog
    #4000000;
    $display("expression_char_lexer_unit regression: fail");
    $finish;
  end

endmodule

[files.f]
design/ecl_pkg.sv
design/ecl_front.sv
design/ecl_queue.sv
design/ecl_back.sv
design/expression_char_lexer_unit.sv
tb/ecl_lexeme_checker.sv
tb/tb_top.sv
